// ----- rtl/crlf_sensor_frame_deframer_core_defines.svh -----
// Assertion macros shared by the deframer RTL.
`ifndef CRLF_SENSOR_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define CRLF_SENSOR_FRAME_DEFRAMER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define CFD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked out of reset.
`define CFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CFD_ASSERT_IMPL(lbl, ante, cons, msg)
`define CFD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/cfd_pkg.sv -----
// Types and constants of the CR LF sensor frame deframer.
package cfd_pkg;

	localparam int FRAME_BYTES   = 24;
	localparam int PAYLOAD_BYTES = FRAME_BYTES - 2;
	localparam int HIST_DEPTH    = FRAME_BYTES - 1;
	localparam int NUM_SAMPLES   = 9;
	localparam int TS_OFFSET     = 18;

	localparam logic [7:0]  CR_BYTE = 8'h0D;
	localparam logic [7:0]  LF_BYTE = 8'h0A;
	localparam logic [4:0]  COUNT_MAX = 5'd31;
	// A frame is good when the CR and at least 22 payload bytes precede the LF.
	localparam logic [4:0]  GOOD_MIN = 5'(PAYLOAD_BYTES + 1);
	localparam logic [15:0] REPORT_PERIOD_RESET = 16'd1000;
	localparam logic [15:0] DECLINED_MAX = 16'hFFFF;

	// Emitter slot numbers: 0..8 are samples, the next one is the report.
	localparam logic [3:0] LAST_SAMPLE = 4'(NUM_SAMPLES - 1);
	localparam logic [3:0] REPORT_SLOT = 4'(NUM_SAMPLES);

	typedef enum logic {
		KIND_SAMPLE = 1'b0,
		KIND_REPORT = 1'b1
	} kind_t;

	// Work handed from the terminator logic to the emitter.
	typedef struct packed {
		logic                              has_frame;
		logic                              has_report;
		logic [NUM_SAMPLES-1:0][15:0]      samples;
		logic [31:0]                       ftime;
		logic [31:0]                       elapsed;
		logic [15:0]                       declined;
	} job_t;

endpackage

// ----- rtl/cfd_byte_cell.sv -----
// One byte cell of the receive history line.
module cfd_byte_cell
	import cfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift_en,
	input  logic [7:0] d_in,
	output logic [7:0] d_out
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift_en) begin
			byte_q <= d_in;
		end
	end

	assign d_out = byte_q;

endmodule

// ----- rtl/cfd_emitter.sv -----
// Job buffer and result serializer with a registered output stage.
`include "crlf_sensor_frame_deframer_core_defines.svh"
module cfd_emitter
	import cfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  job_t               job,
	output logic               job_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_kind,
	output logic [3:0]         sample_index,
	output logic signed [15:0] sample_value,
	output logic [31:0]        frame_time,
	output logic [31:0]        remote_elapsed,
	output logic [15:0]        declined_count,
	output logic               last_of_run
);

	job_t        pend_q;
	logic        pend_valid_q;
	job_t        act_q;
	logic        act_valid_q;
	logic [3:0]  idx_q;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [3:0]  sidx_q;
	logic [15:0] sval_q;
	logic [31:0] ftime_q;
	logic [31:0] elapsed_q;
	logic [15:0] declined_q;
	logic        last_q;

	logic load_out;
	logic is_rep;
	logic item_last;
	logic act_free;
	logic take_pend;

	always_comb begin
		load_out  = act_valid_q && (!out_valid_q || out_ready);
		is_rep    = (idx_q == REPORT_SLOT);
		item_last = is_rep || ((idx_q == LAST_SAMPLE) && !act_q.has_report);
		act_free  = !act_valid_q || (load_out && item_last);
		take_pend = pend_valid_q && act_free;
	end

	// The buffer can take a new job in the cycle its old job moves on.
	assign job_ready = !pend_valid_q || take_pend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (job_valid && job_ready) begin
			pend_valid_q <= 1'b1;
		end else if (take_pend) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			pend_q <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (take_pend) begin
			act_valid_q <= 1'b1;
			idx_q       <= pend_q.has_frame ? 4'd0 : REPORT_SLOT;
		end else if (load_out && item_last) begin
			act_valid_q <= 1'b0;
		end else if (load_out) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_pend) begin
			act_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			ftime_q <= act_q.ftime;
			last_q  <= item_last;
			if (is_rep) begin
				kind_q     <= KIND_REPORT;
				sidx_q     <= '0;
				sval_q     <= '0;
				elapsed_q  <= act_q.elapsed;
				declined_q <= act_q.declined;
			end else begin
				kind_q     <= KIND_SAMPLE;
				sidx_q     <= idx_q;
				sval_q     <= act_q.samples[idx_q];
				elapsed_q  <= '0;
				declined_q <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = kind_q;
	assign sample_index   = sidx_q;
	assign sample_value   = sval_q;
	assign frame_time     = ftime_q;
	assign remote_elapsed = elapsed_q;
	assign declined_count = declined_q;
	assign last_of_run    = last_q;

	`CFD_ASSERT_IMPL(a_report_is_last, out_valid && (result_kind == KIND_REPORT), last_of_run, "report result not marked last")
	`CFD_ASSERT_IMPL(a_last_sample_index, out_valid && (result_kind == KIND_SAMPLE) && last_of_run, sample_index == LAST_SAMPLE, "sample run ended early")
	`CFD_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !last_of_run, out_valid, "gap inside a result run")
	`CFD_ASSERT_IMPL(a_serializer_busy, act_valid_q && !is_rep, act_q.has_frame, "sample slot without frame")

endmodule

// ----- rtl/crlf_sensor_frame_deframer_core.sv -----
// Top level of the CR LF delimited sensor frame deframer.
//
//  Channel   Direction  Handshake              Payload
//  input     in         in_valid / in_ready    rx_byte
//  result    out        out_valid / out_ready  result_kind, sample_index, sample_value,
//                                              frame_time, remote_elapsed,
//                                              declined_count, last_of_run
//  config    in         cfg_valid / cfg_ready  report_period
//
// One byte is taken per cycle while in_ready is high. A byte that is not the LF of a
// CR LF pair only shifts the history line and updates the byte count and CR flag. A
// terminator hands one job of up to ten results to the emitter, which sends one result
// per cycle while out_ready is high, once the job has passed the job buffer and the
// active job register. The one-job buffer in front of the emitter lets input continue;
// in_ready drops only while that buffer holds a job the emitter cannot take at this
// edge because an earlier job still has results to send. Reset is asynchronous and
// clears all control state; the report period returns to 1000. Output stalls hold the
// result register and back up through the emitter into the job buffer.
module crlf_sensor_frame_deframer_core
	import cfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_kind,
	output logic [3:0]         sample_index,
	output logic signed [15:0] sample_value,
	output logic [31:0]        frame_time,
	output logic [31:0]        remote_elapsed,
	output logic [15:0]        declined_count,
	output logic               last_of_run,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        report_period
);

	// The history line: cell 0 holds the newest byte. Every accepted byte
	// moves each cell's content one place toward the old end.
	logic [7:0] hist [HIST_DEPTH];
	logic       in_xfer;

	assign in_xfer = in_valid && in_ready;

	for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
		if (k == 0) begin : g_head
			cfd_byte_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (in_xfer),
				.d_in     (rx_byte),
				.d_out    (hist[k])
			);
		end else begin : g_body
			cfd_byte_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (in_xfer),
				.d_in     (hist[k-1]),
				.d_out    (hist[k])
			);
		end
	end

	// Framing and statistics state.
	logic [15:0] period_q;
	logic [4:0]  count_q;
	logic        saw_cr_q;
	logic [15:0] term_cnt_q;
	logic [15:0] declined_q;
	logic [31:0] last_ts_q;
	logic [31:0] report_ts_q;

	logic        is_term;
	logic        good;
	logic        report;
	logic [15:0] new_tc;
	logic [15:0] new_declined;
	logic [31:0] frame_ts;
	logic [31:0] new_last;
	job_t        job;
	logic        job_valid;
	logic        job_ready;

	// When the terminator arrives, cell 0 holds the CR and cells 22 down to 1 hold
	// payload bytes 0 to 21, oldest first. Samples and timestamp are little-endian.
	always_comb begin
		is_term      = saw_cr_q && (rx_byte == LF_BYTE);
		good         = is_term && (count_q >= GOOD_MIN);
		new_tc       = term_cnt_q + 16'd1;
		report       = is_term && (new_tc >= period_q);
		new_declined = (good || (declined_q == DECLINED_MAX)) ?
			declined_q : declined_q + 16'd1;
		frame_ts     = {hist[PAYLOAD_BYTES-TS_OFFSET-3], hist[PAYLOAD_BYTES-TS_OFFSET-2],
			hist[PAYLOAD_BYTES-TS_OFFSET-1], hist[PAYLOAD_BYTES-TS_OFFSET]};
		new_last     = good ? frame_ts : last_ts_q;

		for (int i = 0; i < NUM_SAMPLES; i++) begin
			job.samples[i] = {hist[PAYLOAD_BYTES-2*i-1], hist[PAYLOAD_BYTES-2*i]};
		end
		job.has_frame  = good;
		job.has_report = report;
		job.ftime      = new_last;
		job.elapsed    = new_last - report_ts_q;
		job.declined   = new_declined;

		// A declined terminator that brings no report produces no results.
		job_valid = in_xfer && (good || report);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= REPORT_PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			period_q <= report_period;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			saw_cr_q    <= 1'b0;
			term_cnt_q  <= '0;
			declined_q  <= '0;
			last_ts_q   <= '0;
			report_ts_q <= '0;
		end else if (in_xfer) begin
			if (is_term) begin
				count_q    <= '0;
				saw_cr_q   <= 1'b0;
				last_ts_q  <= new_last;
				if (report) begin
					term_cnt_q  <= '0;
					declined_q  <= '0;
					report_ts_q <= new_last;
				end else begin
					term_cnt_q <= new_tc;
					declined_q <= new_declined;
				end
			end else begin
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + 5'd1;
				end
				saw_cr_q <= (rx_byte == CR_BYTE);
			end
		end
	end

	// A job transfer is never refused once a byte is taken, because in_ready
	// already waits for room in the job buffer.
	assign in_ready  = job_ready;
	assign cfg_ready = 1'b1;

	cfd_emitter u_emitter (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_valid      (job_valid),
		.job            (job),
		.job_ready      (job_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.sample_index   (sample_index),
		.sample_value   (sample_value),
		.frame_time     (frame_time),
		.remote_elapsed (remote_elapsed),
		.declined_count (declined_count),
		.last_of_run    (last_of_run)
	);

endmodule

// ----- tb/tb_crlf_sensor_frame_deframer_core.sv -----
// Self-checking testbench for the CR LF sensor frame deframer, driven with random byte streams.
module tb_crlf_sensor_frame_deframer_core;
	import cfd_pkg::*;

	// The receiver holds off this long once, so that the job buffer fills
	// and in_ready must drop while the sender keeps offering bytes.
	localparam int HOLD_CYCLES   = 200;
	// Idle cycles allowed after the last expected result, before a
	// register write or the end of the run, for work that makes no result.
	localparam int SETTLE_CYCLES = 16;
	// Cycles without any transfer on any channel before the run is abandoned.
	localparam int IDLE_LIMIT    = 3000;
	// Least number of random bytes sent in each configuration phase.
	localparam int PHASE_ITEMS   = 24;
	localparam int NUM_PHASES    = 6;
	// The phase that carries the long receiver hold-off.
	localparam int STALL_PHASE   = 0;
	// Bare CR LF pairs sent at the start of the hold-off; each one brings a
	// report under period 1, more than the block can hold.
	localparam int STALL_TERMS   = 6;

	// One result as it leaves the block.
	typedef struct packed {
		kind_t        kind;
		logic [3:0]   index;
		logic [15:0]  value;
		logic [31:0]  ftime;
		logic [31:0]  elapsed;
		logic [15:0]  declined;
		logic         last;
	} deframed_result_t;

	// Predicts the results of each accepted byte and checks the block's
	// results against them in order.
	class frame_scoreboard;
		logic [7:0]        history [HIST_DEPTH];
		logic [4:0]        run_len;
		bit                cr_seen;
		logic [15:0]       term_count;
		logic [15:0]       declined;
		logic [31:0]       latest_ts;
		logic [31:0]       report_ts;
		logic [15:0]       period;
		deframed_result_t  pending [$];
		int                errors;

		function new();
			foreach (history[i])
				history[i] = 8'h00;
			run_len    = '0;
			cr_seen    = 1'b0;
			term_count = '0;
			declined   = '0;
			latest_ts  = '0;
			report_ts  = '0;
			period     = REPORT_PERIOD_RESET;
			errors     = 0;
		endfunction

		function void set_period(logic [15:0] p);
			period = p;
		endfunction

		function int outstanding();
			return pending.size();
		endfunction

		// Payload byte k, oldest first, of the frame whose CR is history[0].
		function logic [7:0] payload_at(int k);
			return history[PAYLOAD_BYTES - k];
		endfunction

		function void shift_in(logic [7:0] b);
			for (int i = HIST_DEPTH - 1; i > 0; i--)
				history[i] = history[i - 1];
			history[0] = b;
		endfunction

		function void note_byte(logic [7:0] b);
			deframed_result_t r;
			logic [31:0]      ts;
			int               n;
			n = 0;
			if (!(cr_seen && b == LF_BYTE)) begin
				shift_in(b);
				if (run_len != COUNT_MAX)
					run_len++;
				cr_seen = (b == CR_BYTE);
				return;
			end
			if (run_len >= GOOD_MIN) begin
				ts = {payload_at(TS_OFFSET + 3), payload_at(TS_OFFSET + 2),
				      payload_at(TS_OFFSET + 1), payload_at(TS_OFFSET)};
				latest_ts = ts;
				for (int i = 0; i < NUM_SAMPLES; i++) begin
					r = '0;
					r.kind  = KIND_SAMPLE;
					r.index = 4'(i);
					r.value = {payload_at(2 * i + 1), payload_at(2 * i)};
					r.ftime = ts;
					pending.push_back(r);
					n++;
				end
			end else if (declined != DECLINED_MAX) begin
				declined++;
			end
			term_count = term_count + 16'd1;
			if (term_count >= period) begin
				r = '0;
				r.kind     = KIND_REPORT;
				r.ftime    = latest_ts;
				r.elapsed  = latest_ts - report_ts;
				r.declined = declined;
				pending.push_back(r);
				n++;
				report_ts  = latest_ts;
				declined   = '0;
				term_count = '0;
			end
			if (n > 0)
				pending[pending.size() - 1].last = 1'b1;
			shift_in(b);
			run_len = '0;
			cr_seen = 1'b0;
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
			if (want !== seen) begin
				errors++;
				$display("%0t: %s expected %0h, actual %0h", $time, name, want, seen);
			end
		endfunction

		function void check_result(deframed_result_t got);
			deframed_result_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, actual %0h", $time, got);
				return;
			end
			want = pending.pop_front();
			compare_field("result_kind", want.kind, got.kind);
			compare_field("sample_index", want.index, got.index);
			compare_field("sample_value", want.value, got.value);
			compare_field("frame_time", want.ftime, got.ftime);
			compare_field("remote_elapsed", want.elapsed, got.elapsed);
			compare_field("declined_count", want.declined, got.declined);
			compare_field("last_of_run", want.last, got.last);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte = 8'h00;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               result_kind;
	logic [3:0]         sample_index;
	logic signed [15:0] sample_value;
	logic [31:0]        frame_time;
	logic [31:0]        remote_elapsed;
	logic [15:0]        declined_count;
	logic               last_of_run;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [15:0]        report_period = 16'd0;

	frame_scoreboard  sb = new();
	deframed_result_t seen_result;

	// Phase controls shared by the sender, the receiver and the main sequence.
	int sent_items = 0;
	bit send_eager = 1'b0;
	bit recv_eager = 1'b0;
	bit hold_req   = 1'b0;

	crlf_sensor_frame_deframer_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.sample_index   (sample_index),
		.sample_value   (sample_value),
		.frame_time     (frame_time),
		.remote_elapsed (remote_elapsed),
		.declined_count (declined_count),
		.last_of_run    (last_of_run),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.report_period  (report_period)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Monitor. All channels are sampled at the rising edge, before the block's
	// own updates for that edge land, so a transfer seen here is the one the
	// block takes at this edge. Results are checked before the byte of the same
	// edge is noted, as that byte cannot have caused them yet.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen_result.kind     = kind_t'(result_kind);
				seen_result.index    = sample_index;
				seen_result.value    = sample_value;
				seen_result.ftime    = frame_time;
				seen_result.elapsed  = remote_elapsed;
				seen_result.declined = declined_count;
				seen_result.last     = last_of_run;
				sb.check_result(seen_result);
			end
			if (in_valid && in_ready)
				sb.note_byte(rx_byte);
			if (cfg_valid && cfg_ready)
				sb.set_period(report_period);
		end
	end

	// Watchdog: any transfer on any channel restarts the count.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver. Before each result it holds ready low for a randomly drawn gap, or not
	// at all in an eager phase. A hold-off request drops ready for a long stretch at once,
	// even while a result waits, so that the block backs up into its input.
	initial begin
		int gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				gap = recv_eager ? 0 : $urandom_range(0, 7);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!(out_valid && out_ready) && !hold_req);
		end
	end

	// Offers one byte after a drawn gap and returns at the edge that takes it.
	// Valid is only lowered when a gap follows, so back-to-back bytes keep it high.
	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = send_eager ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (!in_ready);
		sent_items++;
	endtask

	task automatic write_period(logic [15:0] p);
		cfg_valid     <= 1'b1;
		report_period <= p;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Payload bytes are random, with a CR now and then so that a CR not
	// followed by LF is seen as ordinary payload.
	function automatic logic [7:0] draw_payload_byte();
		if ($urandom_range(0, 15) == 0)
			return CR_BYTE;
		return 8'($urandom_range(0, 255));
	endfunction

	// One stretch of traffic: mostly well-formed frames, some short ones that
	// must be declined, and some loose noise with stray CR and LF bytes.
	task automatic send_sequence();
		int pick;
		int len;
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			// A good frame, now and then longer than the line, which also
			// drives the byte count into saturation.
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(PAYLOAD_BYTES + 1, 40)
			                                  : PAYLOAD_BYTES;
			for (int i = 0; i < len; i++)
				send_byte(draw_payload_byte());
			// A doubled CR: the first one is payload, only the second ends the frame.
			if ($urandom_range(0, 4) == 0)
				send_byte(CR_BYTE);
			send_byte(CR_BYTE);
			send_byte(LF_BYTE);
		end else if (pick < 8) begin
			// A short frame; one byte short of good is the case most worth hitting.
			len = ($urandom_range(0, 2) == 0) ? PAYLOAD_BYTES - 1
			                                  : $urandom_range(0, PAYLOAD_BYTES - 1);
			for (int i = 0; i < len; i++)
				send_byte(draw_payload_byte());
			send_byte(CR_BYTE);
			send_byte(LF_BYTE);
		end else begin
			len = $urandom_range(1, 4);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 2))
					0: begin
						send_byte(LF_BYTE);
					end
					1: begin
						send_byte(CR_BYTE);
					end
					default: begin
						send_byte(8'($urandom_range(0, 255)));
					end
				endcase
			end
		end
	endtask

	// Waits until every expected result has arrived, then lets the block
	// settle, since a declined terminator may still be in flight. The first
	// edge lets the monitor note the byte taken at the edge just passed.
	task automatic wait_drained();
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [7:0]  corner_payload [PAYLOAD_BYTES];
		logic [15:0] period_plan [NUM_PHASES];
		int          target;

		// Samples at the extremes of the signed range, minus one, zero, one,
		// a CR pair inside the payload, and a timestamp of all ones so that
		// the elapsed time of a later report wraps.
		corner_payload = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00,
		                   8'h01, 8'h00, 8'h80, 8'h00, 8'h7F, 8'hFF, CR_BYTE, CR_BYTE,
		                   8'h55, 8'hAA, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		// Period 1 reports after every terminator, 0 does too, 65535 never
		// reports in practice, and the step from 65535 down to 2 leaves the
		// terminator count above the new period.
		period_plan = '{16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd2, 16'($urandom_range(1, 8))};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset period: one good frame built from corner
		// values, then a doubled CR before LF, which is a short frame.
		foreach (corner_payload[i])
			send_byte(corner_payload[i]);
		send_byte(CR_BYTE);
		send_byte(LF_BYTE);
		send_byte(CR_BYTE);
		send_byte(CR_BYTE);
		send_byte(LF_BYTE);
		in_valid <= 1'b0;

		for (int p = 0; p < NUM_PHASES; p++) begin
			// The sender pauses here until the block has delivered everything,
			// so the register is only written while the block is idle.
			wait_drained();
			write_period(period_plan[p]);
			send_eager = ($urandom_range(0, 3) == 0);
			recv_eager = ($urandom_range(0, 3) == 0);
			if (p == STALL_PHASE) begin
				send_eager = 1'b1;
				recv_eager = 1'b0;
				hold_req   = 1'b1;
				repeat (STALL_TERMS) begin
					send_byte(CR_BYTE);
					send_byte(LF_BYTE);
				end
			end
			target = sent_items + PHASE_ITEMS;
			while (sent_items < target)
				send_sequence();
			in_valid <= 1'b0;
		end

		wait_drained();
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cfd_pkg.sv
rtl/cfd_byte_cell.sv
rtl/cfd_emitter.sv
rtl/crlf_sensor_frame_deframer_core.sv
tb/tb_crlf_sensor_frame_deframer_core.sv
